FILE: rtl/core/mnd_pkg.sv
// shared widths, register indexes and constants for the disk potential unit
`timescale 1ns / 1ps
`default_nettype none

package mnd_pkg;

	localparam int RADIUS_W = 26;
	localparam int HEIGHT_W = 27;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int POT_W    = 48;
	localparam int GR_W     = 47;
	localparam int GZ_W     = 48;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DISK_MASS    = 2'd0;
	localparam cfg_idx_t REG_SCALE_LENGTH = 2'd1;
	localparam cfg_idx_t REG_SCALE_HEIGHT = 2'd2;

	// G * 1e6 * 2^48, so that mass times this is GM in Q.48
	localparam logic [30:0] GM_UNIT = 31'd1266215183;

	// 2^47, the largest magnitude a negative result may carry
	localparam logic [47:0] MAG_LIM = 48'h8000_0000_0000;

endpackage

`default_nettype wire

FILE: rtl/core/mnd_if.sv
// request, result and configuration channels of the disk potential unit
`timescale 1ns / 1ps
`default_nettype none

interface mnd_pos_if;
	logic                                valid;
	logic                                ready;
	logic [mnd_pkg::RADIUS_W-1:0]        radius;
	logic signed [mnd_pkg::HEIGHT_W-1:0] height;

	modport source (output valid, radius, height, input ready);
	modport sink (input valid, radius, height, output ready);
endinterface

interface mnd_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [mnd_pkg::POT_W-1:0] potential;
	logic [mnd_pkg::GR_W-1:0]         grad_radial;
	logic signed [mnd_pkg::GZ_W-1:0]  grad_vertical;
	logic                             fault;

	modport source (output valid, potential, grad_radial, grad_vertical, fault, input ready);
	modport sink (input valid, potential, grad_radial, grad_vertical, fault, output ready);
endinterface

interface mnd_cfg_if;
	logic                        valid;
	logic                        ready;
	mnd_pkg::cfg_idx_t           index;
	logic [mnd_pkg::CFG_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mnd_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
`default_nettype none

module mnd_div #(
	parameter int NW = 67,
	parameter int DW = 32,
	parameter int QW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic          ovf_s [0:QW];
	logic [DW-1:0] head;

	// upper part of the numerator; quotient overflows when it reaches the divisor
	assign head = DW'(num[NW-1:QW]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head;
			low_s[0] <= num[QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= (head >= den);
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        take;

		assign trial = {rem_s[k-1], low_s[k-1][QW-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign take  = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
				low_s[k] <= {low_s[k-1][QW-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QW-2:0], take};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

`default_nettype wire

FILE: rtl/core/miyamoto_nagai_disk_potential_force_unit.sv
// miyamoto-nagai disk potential and gradient unit, one position per request
// throughput: one request per cycle; a result not taken freezes every stage, nothing lost
// depth is set by the 72-step quotient for the vertical gradient and the two root extractions
// reset: arst_n clears all stage valid bits and the mass, scale length and scale height registers
`timescale 1ns / 1ps
`default_nettype none

module miyamoto_nagai_disk_potential_force_unit (
	input  logic         clk,
	input  logic         arst_n,
	mnd_cfg_if.sink      cfg,
	mnd_pos_if.sink      position,
	mnd_res_if.source    result
);

	import mnd_pkg::*;

	// root widths: s from a 54-bit radicand, q from D shifted up by 8
	localparam int R1 = 27;
	localparam int R2 = 32;

	typedef struct packed {
		logic [25:0] r;
		logic [26:0] zabs;
		logic        neg;
	} front_t;

	typedef struct packed {
		logic [25:0] r;
		logic [27:0] u;
		logic [55:0] d;
		logic        neg;
		logic        sz;
		logic        dz;
	} mid_t;

	typedef struct packed {
		logic        neg;
		logic        sz;
		logic        dz;
		logic [32:0] zs;
	} tail_t;

	typedef struct packed {
		logic [47:0] pot;
		logic [46:0] gr;
		logic        fault;
	} res_t;

	// configuration registers
	logic [CFG_W-1:0] disk_mass_q;
	logic [CFG_W-1:0] scale_length_q;
	logic [CFG_W-1:0] scale_height_q;
	logic [54:0]      gm_q;

	// stage valid bits and global advance
	logic [143:1] v_s;
	logic         en;

	// front end
	logic [26:0]  h_bits;
	logic [26:0]  zabs_in;
	front_t       front_s [1:30];
	logic [53:0]  zsq_s2;
	logic [47:0]  bsq_s2;
	logic [53:0]  v1_s3;

	// root of z^2 + b^2
	logic [R1+1:0]   sq1_rem_s  [1:R1];
	logic [R1-1:0]   sq1_root_s [1:R1];
	logic [2*R1-1:0] sq1_rad_s  [1:R1];

	// s, u and D
	logic [25:0] r_s31;
	logic [26:0] zabs_s31;
	logic        neg_s31;
	logic        sz_s31;
	logic [27:0] u_s31;
	logic [26:0] sg_s31;
	logic [25:0] r_s32;
	logic        neg_s32;
	logic        sz_s32;
	logic [27:0] u_s32;
	logic [55:0] usq_s32;
	logic [51:0] rsq_s32;
	logic [55:0] dsum;
	mid_t        mid_s [33:65];

	// root of D * 2^8
	logic [R2+1:0]   sq2_rem_s  [1:R2];
	logic [R2-1:0]   sq2_root_s [1:R2];
	logic [2*R2-1:0] sq2_rad_s  [1:R2];

	// products feeding the dividers
	logic [31:0]  qg_s66;
	logic [59:0]  pdq_lo_s66;
	logic [59:0]  pdq_hi_s66;
	logic [53:0]  pgr_lo_s66;
	logic [52:0]  pgr_hi_s66;
	logic [55:0]  pgu_lo_s66;
	logic [54:0]  pgu_hi_s66;
	logic [87:0]  dq_sum;
	logic [80:0]  gmr_sum;
	logic [82:0]  gmu_sum;
	logic [87:0]  dq_s67;
	logic [108:0] ngr_s67;
	logic [110:0] ngh_s67;

	// divider outputs
	logic [32:0] zs_quo;
	logic [47:0] pot_quo;
	logic        pot_ovf;
	logic [46:0] gr_quo;
	logic        gr_ovf;
	logic [71:0] h_quo;
	logic        h_ovf;

	tail_t tail_s [66:142];
	res_t  res_s [116:142];

	// vertical gradient back end
	logic [56:0]  hp0_s141;
	logic [56:0]  hp1_s141;
	logic [56:0]  hp2_s141;
	logic         hsat_s141;
	logic [104:0] prod;
	logic [72:0]  p_s142;
	logic         hsatz_s142;

	// output register
	logic [47:0] pot_s143;
	logic [46:0] gr_s143;
	logic [47:0] gz_s143;
	logic        fault_s143;

	// ------------------------------------------------------------------
	// configuration port, always ready; unknown indexes are dropped
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_mass_q    <= '0;
			scale_length_q <= '0;
			scale_height_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DISK_MASS:    disk_mass_q    <= cfg.data;
				REG_SCALE_LENGTH: scale_length_q <= cfg.data;
				REG_SCALE_HEIGHT: scale_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// GM in Q.48, registered from the mass register in the cycle after it changes
	always_ff @(posedge clk) begin
		gm_q <= disk_mass_q * GM_UNIT;
	end

	// ------------------------------------------------------------------
	// handshake: the whole pipe moves unless a finished result is stuck
	// ------------------------------------------------------------------
	assign en = !v_s[143] || result.ready;
	assign position.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[142:1], position.valid};
		end
	end

	// ------------------------------------------------------------------
	// stage 1..3: |z|, squares, z^2 + b^2
	// ------------------------------------------------------------------
	assign h_bits  = position.height;
	assign zabs_in = h_bits[26] ? (27'd0 - h_bits) : h_bits;

	always_ff @(posedge clk) begin
		if (en) begin
			front_s[1].r    <= position.radius;
			front_s[1].zabs <= zabs_in;
			front_s[1].neg  <= h_bits[26];
			zsq_s2          <= front_s[1].zabs * front_s[1].zabs;
			bsq_s2          <= scale_height_q * scale_height_q;
			v1_s3           <= zsq_s2 + {6'b0, bsq_s2};
		end
	end

	// r, |z| and sign ride along while s is extracted
	for (genvar k = 2; k <= 30; k++) begin : g_front
		always_ff @(posedge clk) begin
			if (en) begin
				front_s[k] <= front_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// stages 4..30: s = isqrt(z^2 + b^2), one root bit per stage
	// ------------------------------------------------------------------
	for (genvar k = 1; k <= R1; k++) begin : g_sq1
		logic [R1+1:0]   rem_p;
		logic [R1-1:0]   root_p;
		logic [2*R1-1:0] rad_p;
		logic [R1+3:0]   pre;
		logic [R1+3:0]   trial;
		logic [R1+3:0]   diff;
		logic            take;

		if (k == 1) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = v1_s3;
		end else begin : g_next
			assign rem_p  = sq1_rem_s[k-1];
			assign root_p = sq1_root_s[k-1];
			assign rad_p  = sq1_rad_s[k-1];
		end

		// bring down two radicand bits, try root*4 + 1
		assign pre   = {rem_p, rad_p[2*R1-1:2*R1-2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign diff  = pre - trial;
		assign take  = (pre >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq1_rem_s[k]  <= take ? diff[R1+1:0] : pre[R1+1:0];
				sq1_root_s[k] <= {root_p[R1-2:0], take};
				sq1_rad_s[k]  <= {rad_p[2*R1-3:0], 2'b00};
			end
		end
	end

	// ------------------------------------------------------------------
	// stages 31..33: u = a + s, squares, D = R^2 + u^2
	// ------------------------------------------------------------------
	assign dsum = usq_s32 + {4'b0, rsq_s32};

	always_ff @(posedge clk) begin
		if (en) begin
			r_s31    <= front_s[30].r;
			zabs_s31 <= front_s[30].zabs;
			neg_s31  <= front_s[30].neg;
			sz_s31   <= (sq1_root_s[R1] == '0);
			u_s31    <= {4'b0, scale_length_q} + {1'b0, sq1_root_s[R1]};
			// divisor for |z|/s, kept nonzero; a zero s is flagged instead
			sg_s31   <= (sq1_root_s[R1] == '0) ? 27'd1 : sq1_root_s[R1];

			r_s32    <= r_s31;
			neg_s32  <= neg_s31;
			sz_s32   <= sz_s31;
			u_s32    <= u_s31;
			usq_s32  <= u_s31 * u_s31;
			rsq_s32  <= r_s31 * r_s31;

			mid_s[33].r   <= r_s32;
			mid_s[33].u   <= u_s32;
			mid_s[33].d   <= dsum;
			mid_s[33].neg <= neg_s32;
			mid_s[33].sz  <= sz_s32;
			mid_s[33].dz  <= (dsum == '0);
		end
	end

	for (genvar k = 34; k <= 65; k++) begin : g_mid
		always_ff @(posedge clk) begin
			if (en) begin
				mid_s[k] <= mid_s[k-1];
			end
		end
	end

	// |z| / s in Q.32, runs beside the second root (stages 32..65)
	mnd_div #(
		.NW(59),
		.DW(27),
		.QW(33)
	) u_div_zs (
		.clk (clk),
		.en  (en),
		.num ({zabs_s31, 32'b0}),
		.den (sg_s31),
		.quo (zs_quo),
		.ovf ()
	);

	// ------------------------------------------------------------------
	// stages 34..65: q = isqrt(D * 2^8), sqrt(D) in Q.4
	// ------------------------------------------------------------------
	for (genvar k = 1; k <= R2; k++) begin : g_sq2
		logic [R2+1:0]   rem_p;
		logic [R2-1:0]   root_p;
		logic [2*R2-1:0] rad_p;
		logic [R2+3:0]   pre;
		logic [R2+3:0]   trial;
		logic [R2+3:0]   diff;
		logic            take;

		if (k == 1) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = {mid_s[33].d, 8'b0};
		end else begin : g_next
			assign rem_p  = sq2_rem_s[k-1];
			assign root_p = sq2_root_s[k-1];
			assign rad_p  = sq2_rad_s[k-1];
		end

		assign pre   = {rem_p, rad_p[2*R2-1:2*R2-2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign diff  = pre - trial;
		assign take  = (pre >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq2_rem_s[k]  <= take ? diff[R2+1:0] : pre[R2+1:0];
				sq2_root_s[k] <= {root_p[R2-2:0], take};
				sq2_rad_s[k]  <= {rad_p[2*R2-3:0], 2'b00};
			end
		end
	end

	// ------------------------------------------------------------------
	// stages 66..67: split products GM*R, GM*u and D*q, then their sums
	// ------------------------------------------------------------------
	assign dq_sum  = {pdq_hi_s66, 28'b0} + {28'b0, pdq_lo_s66};
	assign gmr_sum = {pgr_hi_s66, 28'b0} + {27'b0, pgr_lo_s66};
	assign gmu_sum = {pgu_hi_s66, 28'b0} + {27'b0, pgu_lo_s66};

	always_ff @(posedge clk) begin
		if (en) begin
			// zero D gives zero q; the divisors are forced to one and the result masked
			qg_s66     <= mid_s[65].dz ? 32'd1 : sq2_root_s[R2];
			pdq_lo_s66 <= mid_s[65].d[27:0] * sq2_root_s[R2];
			pdq_hi_s66 <= mid_s[65].d[55:28] * sq2_root_s[R2];
			pgr_lo_s66 <= gm_q[27:0] * mid_s[65].r;
			pgr_hi_s66 <= gm_q[54:28] * mid_s[65].r;
			pgu_lo_s66 <= gm_q[27:0] * mid_s[65].u;
			pgu_hi_s66 <= gm_q[54:28] * mid_s[65].u;

			tail_s[66].neg <= mid_s[65].neg;
			tail_s[66].sz  <= mid_s[65].sz;
			tail_s[66].dz  <= mid_s[65].dz;
			tail_s[66].zs  <= zs_quo;

			dq_s67  <= tail_s[66].dz ? 88'd1 : dq_sum;
			ngr_s67 <= {gmr_sum, 28'b0};
			ngh_s67 <= {gmu_sum, 28'b0};
		end
	end

	for (genvar k = 67; k <= 142; k++) begin : g_tail
		always_ff @(posedge clk) begin
			if (en) begin
				tail_s[k] <= tail_s[k-1];
			end
		end
	end

	// |potential| = GM * 2^12 / q, stages 67..115
	mnd_div #(
		.NW(67),
		.DW(32),
		.QW(48)
	) u_div_pot (
		.clk (clk),
		.en  (en),
		.num ({gm_q, 12'b0}),
		.den (qg_s66),
		.quo (pot_quo),
		.ovf (pot_ovf)
	);

	// radial gradient = GM * R * 2^28 / (D * q), stages 68..115
	mnd_div #(
		.NW(109),
		.DW(88),
		.QW(47)
	) u_div_gr (
		.clk (clk),
		.en  (en),
		.num (ngr_s67),
		.den (dq_s67),
		.quo (gr_quo),
		.ovf (gr_ovf)
	);

	// H = GM * u * 2^28 / (D * q), stages 68..140; past 2^72 the vertical
	// gradient saturates anyway since |z|/s is then at least 2^7 in Q.32
	mnd_div #(
		.NW(111),
		.DW(88),
		.QW(72)
	) u_div_h (
		.clk (clk),
		.en  (en),
		.num (ngh_s67),
		.den (dq_s67),
		.quo (h_quo),
		.ovf (h_ovf)
	);

	// ------------------------------------------------------------------
	// stage 116: clamp potential and radial gradient, then hold them
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_s[115].dz) begin
				res_s[116].pot   <= '0;
				res_s[116].gr    <= '0;
				res_s[116].fault <= 1'b0;
			end else begin
				if (pot_ovf || (pot_quo > MAG_LIM)) begin
					res_s[116].pot <= 48'd0 - MAG_LIM;
				end else begin
					res_s[116].pot <= 48'd0 - pot_quo;
				end
				res_s[116].gr    <= gr_ovf ? {GR_W{1'b1}} : gr_quo;
				res_s[116].fault <= pot_ovf || (pot_quo > MAG_LIM) || gr_ovf;
			end
		end
	end

	for (genvar k = 117; k <= 142; k++) begin : g_res
		always_ff @(posedge clk) begin
			if (en) begin
				res_s[k] <= res_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// stages 141..142: H * |z|/s in three partial products, then >> 32
	// ------------------------------------------------------------------
	assign prod = {48'b0, hp0_s141} + {24'b0, hp1_s141, 24'b0} + {hp2_s141, 48'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			hp0_s141   <= h_quo[23:0] * tail_s[140].zs;
			hp1_s141   <= h_quo[47:24] * tail_s[140].zs;
			hp2_s141   <= h_quo[71:48] * tail_s[140].zs;
			hsat_s141  <= h_ovf;

			p_s142     <= prod[104:32];
			// a zero ratio (z = 0) gives zero however large H is
			hsatz_s142 <= hsat_s141 && (tail_s[141].zs != '0);
		end
	end

	// ------------------------------------------------------------------
	// stage 143: sign and clamp the vertical gradient, output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			pot_s143 <= res_s[142].pot;
			gr_s143  <= res_s[142].gr;
			if (tail_s[142].dz) begin
				gz_s143    <= '0;
				fault_s143 <= 1'b1;
			end else if (tail_s[142].sz) begin
				// zero s: no vertical ratio, flagged
				gz_s143    <= '0;
				fault_s143 <= 1'b1;
			end else if (tail_s[142].neg) begin
				if (hsatz_s142 || (p_s142 > {25'b0, MAG_LIM})) begin
					gz_s143    <= 48'd0 - MAG_LIM;
					fault_s143 <= 1'b1;
				end else begin
					gz_s143    <= 48'd0 - p_s142[47:0];
					fault_s143 <= res_s[142].fault;
				end
			end else begin
				if (hsatz_s142 || (p_s142 > {25'b0, MAG_LIM - 48'd1})) begin
					gz_s143    <= MAG_LIM - 48'd1;
					fault_s143 <= 1'b1;
				end else begin
					gz_s143    <= p_s142[47:0];
					fault_s143 <= res_s[142].fault;
				end
			end
		end
	end

	assign result.valid         = v_s[143];
	assign result.potential     = pot_s143;
	assign result.grad_radial   = gr_s143;
	assign result.grad_vertical = gz_s143;
	assign result.fault         = fault_s143;

endmodule

`default_nettype wire

FILE: dv/mnd_tb_if.sv
// note: the channel interfaces come with the rtl in rtl/core/mnd_if.sv; nothing to add here
`timescale 1ns / 1ps

FILE: dv/tb_top.sv
// self-checking testbench for the miyamoto-nagai disk potential unit
`timescale 1ns / 1ps

module tb_top;
	import mnd_pkg::*;

	localparam int LATENCY = 143;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [63:0] LIM47 = 64'h8000_0000_0000;

	typedef struct packed {
		logic [47:0] pot;
		logic [46:0] gr;
		logic [47:0] gz;
		logic        fault;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mnd_cfg_if cfg_ch ();
	mnd_pos_if pos_ch ();
	mnd_res_if res_ch ();

	miyamoto_nagai_disk_potential_force_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .position(pos_ch.sink),
		.result(res_ch.source)
	);

	always #5 clk = ~clk;

	// shadow copy of the mass and scale registers
	logic [23:0] mass_q, scale_a, scale_b;
	force_t forces_due[$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 1'b0; // no idling on either side when set

	// bit-serial integer square root
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// expected potential and gradients at one position
	function automatic force_t disk_force(input logic [25:0] rad, input logic [26:0] hgt);
		force_t f;
		logic [63:0] zabs, s, u, d, q, gm, zs;
		logic [127:0] w, h, p;
		logic neg;
		f = '0;
		neg = hgt[26];
		zabs = neg ? (64'h800_0000 - 64'(hgt)) : 64'(hgt);
		s = root64(zabs * zabs + 64'(scale_b) * 64'(scale_b));
		u = 64'(scale_a) + s;
		d = 64'(rad) * 64'(rad) + u * u;
		if (d == 0) begin
			f.fault = 1'b1;
			return f;
		end
		q = root64(d << 8);
		gm = 64'(mass_q) * 64'(GM_UNIT);
		w = (128'(gm) << 12) / 128'(q);
		if (w > 128'(LIM47)) begin
			w = 128'(LIM47);
			f.fault = 1'b1;
		end
		f.pot = 48'(-w);
		w = ((((128'(gm) * 128'(rad)) << 28) / 128'(d)) / 128'(q));
		if (w > 128'(LIM47 - 1)) begin
			w = 128'(LIM47 - 1);
			f.fault = 1'b1;
		end
		f.gr = 47'(w);
		if (s == 0) begin
			f.fault = 1'b1;
			return f;
		end
		zs = (zabs << 32) / s;
		h = ((((128'(gm) * 128'(u)) << 28) / 128'(d)) / 128'(q));
		if (h[127:64] >= 64'd1 << 15) h = 128'd1 << 79;
		p = (h * 128'(zs)) >> 32;
		if (p > 128'(neg ? LIM47 : LIM47 - 1)) begin
			p = 128'(neg ? LIM47 : LIM47 - 1);
			f.fault = 1'b1;
		end
		f.gz = neg ? 48'(-p) : 48'(p);
		return f;
	endfunction

	// one register write; the shadow copy follows the accepted write
	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_DISK_MASS:    mass_q = val;
			REG_SCALE_LENGTH: scale_a = val;
			REG_SCALE_HEIGHT: scale_b = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_disk(input logic [23:0] m, input logic [23:0] a, input logic [23:0] b);
		write_reg(REG_DISK_MASS, m);
		write_reg(REG_SCALE_LENGTH, a);
		write_reg(REG_SCALE_HEIGHT, b);
	endtask

	// one request; idles first at random unless quiet, valid stays up after accept
	task automatic send_position(input logic [25:0] rad, input logic [26:0] hgt);
		if (!quiet)
			while ($urandom_range(99) < 36) begin
				pos_ch.valid <= 1'b0;
				@(posedge clk);
			end
		pos_ch.valid <= 1'b1;
		pos_ch.radius <= rad;
		pos_ch.height <= hgt;
		do @(posedge clk); while (!pos_ch.ready);
		forces_due.push_back(disk_force(rad, hgt));
	endtask

	// drain every expected result, then let the pipe settle
	task automatic drain();
		pos_ch.valid <= 1'b0;
		while (forces_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		force_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.potential, res_ch.grad_radial, res_ch.grad_vertical, res_ch.fault};
			if (forces_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = forces_due.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch pot %h/%h gr %h/%h gz %h/%h fault %b/%b",
							want.pot, got.pot, want.gr, got.gr, want.gz, got.gz,
							want.fault, got.fault);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk)
		res_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 36);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// extremes of both fields, zero denominators and zero s
	task automatic test_directed();
		set_disk(24'd0, 24'd0, 24'd0);
		send_position(26'd0, 27'd0);
		send_position(26'd0, 27'd0);
		drain();
		set_disk(24'hFFFFFF, 24'd0, 24'd0);
		send_position(26'd0, 27'd0);           // zero denominator
		send_position(26'd1, 27'd0);           // zero s, saturates
		send_position(26'h3FFFFFF, 27'd0);
		send_position(26'd0, 27'd1);
		send_position(26'd0, 27'h7FFFFFF);     // z = -1 lsb
		send_position(26'd0, 27'h4000000);     // most negative z
		send_position(26'd0, 27'h3FFFFFF);
		drain();
		set_disk(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_position(26'h3FFFFFF, 27'h3FFFFFF);
		send_position(26'h3FFFFFF, 27'h4000000);
		send_position(26'd0, 27'd0);
		send_position(26'h2AAAAAA, 27'h5555555);
		drain();
		set_disk(24'd1, 24'h010000, 24'h004000);
		write_reg(2'd3, 24'h123456);           // ignored index
		send_position(26'h010000, 27'h010000);
		send_position(26'h1555555, 27'h2AAAAAA);
		send_position(26'd5, 27'h7FF0000);
		drain();
	endtask

	// random positions under several disk settings
	task automatic test_random();
		logic [25:0] rad;
		logic [26:0] hgt;
		for (int phase = 0; phase < 6; phase++) begin
			set_disk($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(5000)),
				24'($urandom_range(phase == 5 ? 24'hFFFFFF : 24'h80000)),
				phase == 4 ? 24'd0 : 24'($urandom_range(24'h40000)));
			quiet = (phase == 2);
			for (int n = 0; n < 100; n++) begin
				case ($urandom_range(3))
					0: begin rad = 26'($urandom); hgt = 27'($urandom); end
					1: begin rad = 26'($urandom_range(26'h100000));
						hgt = 27'($signed(27'($urandom_range(26'h80000))) -
							27'sh40000); end
					2: begin rad = 26'($urandom_range(26'h1000)); hgt = 27'($urandom_range(7)); end
					default: begin rad = 26'($urandom_range(26'h3FFFFFF, 26'h3F00000));
						hgt = 27'($urandom); end
				endcase
				send_position(rad, hgt);
			end
			quiet = 1'b0;
			drain();
		end
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DISK_MASS;
		cfg_ch.data = '0;
		pos_ch.valid = 1'b0;
		pos_ch.radius = '0;
		pos_ch.height = '0;
		res_ch.ready = 1'b0;
		mass_q = 0;
		scale_a = 0;
		scale_b = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (mismatches == 0 && forces_due.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mnd_pkg.sv
rtl/core/mnd_if.sv
rtl/core/mnd_div.sv
rtl/core/miyamoto_nagai_disk_potential_force_unit.sv
dv/mnd_tb_if.sv
dv/tb_top.sv
